FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the hole allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error(msg);

// Delayed implication: the consequence is checked a given delay after the antecedent.
`define ASSERT_DELAY(lbl, clk, rst_n, a, n, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> ##n (c)) \
		else $error(msg);

`endif

FILE: rtl/bfha_pkg.sv
// Shared types, codes and defaults of the best-fit hole allocator.
package bfha_pkg;

	localparam int MAX_HOLES_DEF = 16;
	localparam int SIZE_BITS_DEF = 16;

	localparam int TYPE_BITS   = 2;
	localparam int AMOUNT_BITS = 16;
	localparam int STATUS_BITS = 2;
	localparam int TOTAL_BITS  = 20;

	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 20'hFFFFF;

	localparam logic [TYPE_BITS-1:0] REQ_LOAD   = 2'd0;
	localparam logic [TYPE_BITS-1:0] REQ_ALLOC  = 2'd1;
	localparam logic [TYPE_BITS-1:0] REQ_REPORT = 2'd2;
	// Unused type code; behaves as a report.
	localparam logic [TYPE_BITS-1:0] REQ_SPARE  = 2'd3;

	localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_NOFIT = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [TYPE_BITS-1:0]   req_type;
		logic [AMOUNT_BITS-1:0] amount;
	} bfha_req_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [AMOUNT_BITS-1:0] granted_size;
		logic [AMOUNT_BITS-1:0] waste;
		logic [TOTAL_BITS-1:0]  internal_total;
		logic [TOTAL_BITS-1:0]  external_total;
	} bfha_rsp_t;

	// Per-phase commands broadcast from the sequencer to every cell.
	typedef struct packed {
		logic eval;
		logic load;
		logic grant;
	} bfha_ctl_t;

endpackage

FILE: rtl/bfha_cell.sv
// One slot of the sorted hole row: size, used flag and per-transaction match flags.
module bfha_cell #(
	parameter int SIZE_BITS = bfha_pkg::SIZE_BITS_DEF,
	parameter int CNT_BITS  = 5,
	parameter int IDX       = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bfha_pkg::bfha_ctl_t   ctl,
	input  logic [CNT_BITS-1:0]   count,
	input  logic [SIZE_BITS-1:0]  amount,
	input  logic                  pick,
	input  logic [SIZE_BITS-1:0]  left_size,
	input  logic                  left_used,
	input  logic                  left_ins,
	output logic [SIZE_BITS-1:0]  size,
	output logic                  used,
	output logic                  ins,
	output logic                  fit
);

	logic [SIZE_BITS-1:0] size_q;
	logic                 used_q;
	logic                 ins_q;
	logic                 fit_q;
	logic                 occ;

	assign occ = count > CNT_BITS'(IDX);

	// Hole size: shift in from the left neighbor, or take the new hole at the boundary.
	always_ff @(posedge clk) begin
		if (ctl.load && ins_q) begin
			size_q <= left_ins ? left_size : amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			ins_q  <= 1'b0;
			fit_q  <= 1'b0;
		end else begin
			if (ctl.eval) begin
				// Insert point lies at or left of an empty slot or a larger hole.
				ins_q <= !occ || (size_q > amount);
				fit_q <= occ && !used_q && (amount <= size_q);
			end
			if (ctl.load && ins_q) begin
				used_q <= left_ins ? left_used : 1'b0;
			end else if (ctl.grant && pick) begin
				used_q <= 1'b1;
			end
		end
	end

	assign size = size_q;
	assign used = used_q;
	assign ins  = ins_q;
	assign fit  = fit_q;

endmodule

FILE: rtl/best_fit_hole_allocator.sv
// Top level of the best-fit hole allocator: sequencer, totals and the row of hole cells.
//
// The block keeps up to MAX_HOLES hole sizes in ascending order in a row of cells,
// each with a used flag. A load transaction inserts a free hole after any holes of
// equal size, or answers table full. An allocate transaction grants the smallest free
// hole that is at least the request (the first fitting one in sorted order), marks it
// used and adds the waste to the internal total, or answers no fit. A report
// transaction, and the unused type code, only return the totals. Every transaction
// returns exactly one result carrying the internal total and the free capacity
// (external total), both saturating at the 20-bit maximum.
// Timing: start is taken while busy is low; busy then stays high through the evaluate,
// pick, apply and respond states, and the result appears with done for one cycle right
// after. A new start is taken in that same cycle, but not before: a new transaction is
// accepted only once the last one is through the four-phase sequencer that drives the
// cell row. The receiver cannot stall: sample rsp whenever done is high. No clearing
// pass is needed after reset.
`include "assert_macros.svh"

module best_fit_hole_allocator #(
	parameter int MAX_HOLES = bfha_pkg::MAX_HOLES_DEF,
	parameter int SIZE_BITS = bfha_pkg::SIZE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bfha_pkg::bfha_req_t req,
	output logic                done,
	output bfha_pkg::bfha_rsp_t rsp
);

	localparam int CNT_BITS = $clog2(MAX_HOLES + 1);
	// Holes are never freed, so both sums stay below MAX_HOLES full-size holes.
	localparam int SUM_BITS = SIZE_BITS + CNT_BITS;
	localparam int TW = (SUM_BITS > bfha_pkg::TOTAL_BITS) ? SUM_BITS : bfha_pkg::TOTAL_BITS;
	localparam int FW = (SIZE_BITS > bfha_pkg::AMOUNT_BITS) ? SIZE_BITS : bfha_pkg::AMOUNT_BITS;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EVAL  = 5'b00010,
		S_PICK  = 5'b00100,
		S_APPLY = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t                 state_q;
	bfha_pkg::bfha_req_t    req_q;
	logic [SIZE_BITS-1:0]   amt_q;
	logic [CNT_BITS-1:0]    hole_count_q;
	logic [SUM_BITS-1:0]    waste_sum_q;
	logic [SUM_BITS-1:0]    free_sum_q;
	logic                   full_q;
	logic [MAX_HOLES-1:0]   pick_q;
	logic                   hit_q;
	logic [SIZE_BITS-1:0]   gsize_q;
	bfha_pkg::bfha_rsp_t    rsp_q;
	logic                   done_q;

	logic                   accept;
	logic                   is_load;
	logic                   is_alloc;
	logic [FW-1:0]          amt_ext;
	bfha_pkg::bfha_ctl_t    ctl;

	logic [SIZE_BITS-1:0]   cell_size [MAX_HOLES];
	logic [MAX_HOLES-1:0]   cell_used;
	logic [MAX_HOLES-1:0]   cell_ins;
	logic [MAX_HOLES-1:0]   fit_vec;
	logic [SIZE_BITS-1:0]   granted_or;

	logic [SIZE_BITS-1:0]   waste_w;
	logic [SUM_BITS-1:0]    waste_sum_d;
	logic [SUM_BITS-1:0]    free_sum_d;
	logic [TW-1:0]          int_ext;
	logic [TW-1:0]          ext_ext;
	logic [FW-1:0]          gsize_ext;
	logic [FW-1:0]          waste_ext;
	bfha_pkg::bfha_rsp_t    rsp_d;

	assign accept   = start && (state_q == S_IDLE);
	assign is_load  = req_q.req_type == bfha_pkg::REQ_LOAD;
	assign is_alloc = req_q.req_type == bfha_pkg::REQ_ALLOC;
	// Keep only the low SIZE_BITS of the amount, zero-extend if storage is wider.
	assign amt_ext  = FW'(req.amount);

	// Broadcast phase commands to the row.
	always_comb begin
		ctl       = '0;
		ctl.eval  = state_q == S_EVAL;
		ctl.load  = (state_q == S_APPLY) && is_load && !full_q;
		ctl.grant = (state_q == S_APPLY) && is_alloc;
	end

	// Cell row: each cell hands its size, used flag and insert flag to its right neighbor.
	for (genvar i = 0; i < MAX_HOLES; i++) begin : g_cell
		logic [SIZE_BITS-1:0] l_size;
		logic                 l_used;
		logic                 l_ins;

		if (i == 0) begin : g_head
			assign l_size = '0;
			assign l_used = 1'b0;
			assign l_ins  = 1'b0;
		end else begin : g_body
			assign l_size = cell_size[i-1];
			assign l_used = cell_used[i-1];
			assign l_ins  = cell_ins[i-1];
		end

		bfha_cell #(
			.SIZE_BITS (SIZE_BITS),
			.CNT_BITS  (CNT_BITS),
			.IDX       (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.count     (hole_count_q),
			.amount    (amt_q),
			.pick      (pick_q[i]),
			.left_size (l_size),
			.left_used (l_used),
			.left_ins  (l_ins),
			.size      (cell_size[i]),
			.used      (cell_used[i]),
			.ins       (cell_ins[i]),
			.fit       (fit_vec[i])
		);
	end

	// Granted size: at most one pick bit is set, so OR the masked sizes.
	always_comb begin
		granted_or = '0;
		for (int i = 0; i < MAX_HOLES; i++) begin
			granted_or = granted_or | (pick_q[i] ? cell_size[i] : '0);
		end
	end

	// Response math: waste, new totals, saturated result fields.
	always_comb begin
		waste_w     = gsize_q - amt_q;
		waste_sum_d = waste_sum_q;
		free_sum_d  = free_sum_q;
		if (is_alloc && hit_q) begin
			waste_sum_d = waste_sum_q + SUM_BITS'(waste_w);
			free_sum_d  = free_sum_q - SUM_BITS'(gsize_q);
		end else if (is_load && !full_q) begin
			free_sum_d  = free_sum_q + SUM_BITS'(amt_q);
		end
		int_ext   = TW'(waste_sum_d);
		ext_ext   = TW'(free_sum_d);
		gsize_ext = FW'(gsize_q);
		waste_ext = FW'(waste_w);

		rsp_d              = '0;
		rsp_d.status       = bfha_pkg::ST_OK;
		rsp_d.granted_size = '0;
		rsp_d.waste        = '0;
		if (is_load && full_q) begin
			rsp_d.status = bfha_pkg::ST_FULL;
		end else if (is_alloc && !hit_q) begin
			rsp_d.status = bfha_pkg::ST_NOFIT;
		end else if (is_alloc) begin
			rsp_d.granted_size = gsize_ext[bfha_pkg::AMOUNT_BITS-1:0];
			rsp_d.waste        = waste_ext[bfha_pkg::AMOUNT_BITS-1:0];
		end
		rsp_d.internal_total = (int_ext > TW'(bfha_pkg::TOTAL_MAX)) ?
			bfha_pkg::TOTAL_MAX : int_ext[bfha_pkg::TOTAL_BITS-1:0];
		rsp_d.external_total = (ext_ext > TW'(bfha_pkg::TOTAL_MAX)) ?
			bfha_pkg::TOTAL_MAX : ext_ext[bfha_pkg::TOTAL_BITS-1:0];
	end

	// Payload registers: hold the request for the whole transaction, capture the granted size and the response.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			amt_q <= amt_ext[SIZE_BITS-1:0];
		end
		if (state_q == S_APPLY) begin
			gsize_q <= granted_or;
		end
		if (state_q == S_RESP) begin
			rsp_q <= rsp_d;
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			hole_count_q <= '0;
			waste_sum_q  <= '0;
			free_sum_q   <= '0;
			full_q       <= 1'b0;
			pick_q       <= '0;
			hit_q        <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					// Cells register their match flags this cycle.
					full_q  <= hole_count_q == CNT_BITS'(MAX_HOLES);
					state_q <= S_PICK;
				end
				S_PICK: begin
					// Isolate the lowest fitting slot: smallest fitting hole.
					pick_q  <= fit_vec & ~(fit_vec - MAX_HOLES'(1));
					hit_q   <= |fit_vec;
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (ctl.load) begin
						hole_count_q <= hole_count_q + CNT_BITS'(1);
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					waste_sum_q <= waste_sum_d;
					free_sum_q  <= free_sum_d;
					pick_q      <= '0;
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	`ASSERT_IMPLIES(a_pick_onehot0, clk, arst_n, 1'b1, $onehot0(pick_q), "more than one hole picked")
	`ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, hole_count_q <= CNT_BITS'(MAX_HOLES), "hole count beyond table depth")
	`ASSERT_DELAY(a_result_latency, clk, arst_n, start && !busy, 5, done, "result missing five cycles after start")
	`ASSERT_IMPLIES(a_full_status, clk, arst_n, done && (rsp.status == bfha_pkg::ST_FULL), hole_count_q == CNT_BITS'(MAX_HOLES), "table full reported below capacity")

endmodule

FILE: tb/tb_best_fit_hole_allocator.sv
// Self-checking testbench of the best-fit hole allocator: directed and random transactions.
`timescale 1ns / 100ps

module tb_best_fit_hole_allocator;

	localparam int HOLES     = bfha_pkg::MAX_HOLES_DEF;
	localparam int N_RANDOM  = 700;
	localparam int GAP_MAX   = 13;
	localparam int TAIL_WAIT = 10;
	localparam int AB        = bfha_pkg::AMOUNT_BITS;
	localparam int TB_W      = bfha_pkg::TOTAL_BITS;

	// One pending request with the idle cycles to insert ahead of it.
	typedef struct {
		bfha_pkg::bfha_req_t req;
		int                  gap;
		bit                  drain;
	} hole_txn_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	bfha_pkg::bfha_req_t req;
	logic                done;
	bfha_pkg::bfha_rsp_t rsp;

	hole_txn_t           pending_txn_q[$];
	bfha_pkg::bfha_rsp_t awaited_rsp_q[$];

	// Prediction state: sorted hole sizes, used flags and running totals.
	logic [AB-1:0] hole_sz [HOLES];
	bit            hole_taken [HOLES];
	int            n_holes;
	longint        waste_acc;
	longint        free_acc;

	// Driver bookkeeping.
	hole_txn_t next_txn;
	bit        have_next;
	int        idle_left;
	bit        took_txn;
	int        err_cnt;

	best_fit_hole_allocator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Compute the response of one accepted transaction and advance the hole table.
	function automatic bfha_pkg::bfha_rsp_t next_alloc_rsp(bfha_pkg::bfha_req_t r);
		bfha_pkg::bfha_rsp_t o;
		int                  pos;
		int                  k;
		bit                  hit;
		o = '0;
		o.status = bfha_pkg::ST_OK;
		hit = 1'b0;
		case (r.req_type)
			bfha_pkg::REQ_LOAD: begin
				if (n_holes >= HOLES) begin
					o.status = bfha_pkg::ST_FULL;
				end else begin
					// Insert after any holes of equal size.
					pos = n_holes;
					while (pos > 0 && hole_sz[pos-1] > r.amount)
						pos--;
					for (k = n_holes; k > pos; k--) begin
						hole_sz[k]    = hole_sz[k-1];
						hole_taken[k] = hole_taken[k-1];
					end
					hole_sz[pos]    = r.amount;
					hole_taken[pos] = 1'b0;
					n_holes++;
					free_acc += longint'(r.amount);
				end
			end
			bfha_pkg::REQ_ALLOC: begin
				// First free fitting hole in ascending order is the best fit.
				for (k = 0; k < n_holes; k++) begin
					if (!hit && !hole_taken[k] && r.amount <= hole_sz[k]) begin
						hit            = 1'b1;
						hole_taken[k]  = 1'b1;
						o.granted_size = hole_sz[k];
						o.waste        = hole_sz[k] - r.amount;
						waste_acc     += longint'(hole_sz[k]) - longint'(r.amount);
						free_acc      -= longint'(hole_sz[k]);
					end
				end
				if (!hit)
					o.status = bfha_pkg::ST_NOFIT;
			end
			default: begin
				// Report and the unused code only return the totals.
			end
		endcase
		o.internal_total = (waste_acc > longint'(bfha_pkg::TOTAL_MAX)) ?
			bfha_pkg::TOTAL_MAX : waste_acc[TB_W-1:0];
		o.external_total = (free_acc > longint'(bfha_pkg::TOTAL_MAX)) ?
			bfha_pkg::TOTAL_MAX : free_acc[TB_W-1:0];
		return o;
	endfunction

	task automatic check_field(string fname, logic [TB_W-1:0] want,
			logic [TB_W-1:0] got);
		if (want !== got) begin
			err_cnt++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
		end
	endtask

	task automatic add_txn(logic [bfha_pkg::TYPE_BITS-1:0] kind, logic [AB-1:0] amt,
			int gap, bit drain);
		hole_txn_t t;
		t.req.req_type = kind;
		t.req.amount   = amt;
		t.gap          = gap;
		t.drain        = drain;
		pending_txn_q.push_back(t);
	endtask

	// Monitor: sample at the rising edge, check results, predict accepted transactions.
	always @(posedge clk) begin
		bfha_pkg::bfha_rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (awaited_rsp_q.size() == 0) begin
					err_cnt++;
					$display("%0t ns: unexpected result, expected none, actual %h", $time, rsp);
				end else begin
					want = awaited_rsp_q.pop_front();
					check_field("status", TB_W'(want.status), TB_W'(rsp.status));
					check_field("granted_size", TB_W'(want.granted_size),
						TB_W'(rsp.granted_size));
					check_field("waste", TB_W'(want.waste), TB_W'(rsp.waste));
					check_field("internal_total", want.internal_total, rsp.internal_total);
					check_field("external_total", want.external_total, rsp.external_total);
				end
			end
			// A transaction moves when start is high and busy is low at this edge.
			took_txn = start && !busy;
			if (took_txn)
				awaited_rsp_q.push_back(next_alloc_rsp(req));
		end else begin
			took_txn = 1'b0;
		end
	end

	// Driver: change inputs at the falling edge; one assignment to start per step.
	always @(negedge clk) begin
		logic drive_start;
		if (arst_n) begin
			// Hold start while the current transaction waits for acceptance.
			drive_start = start && !took_txn;
			if (!drive_start) begin
				if (!have_next && pending_txn_q.size() != 0) begin
					next_txn  = pending_txn_q.pop_front();
					have_next = 1'b1;
					idle_left = next_txn.gap;
				end
				if (have_next) begin
					if (idle_left > 0) begin
						idle_left--;
					end else if (!next_txn.drain || awaited_rsp_q.size() == 0) begin
						// A drain transaction holds off until every result is in.
						drive_start = 1'b1;
						req        <= next_txn.req;
						have_next   = 1'b0;
					end
				end
			end
			start <= drive_start;
		end
	end

	// Stop a run that hangs.
	initial begin
		#2ms;
		$display("[best_fit_hole_allocator] ERROR");
		$finish;
	end

	initial begin
		int  i;
		int  pick;
		int  gap;
		bit  burst;
		logic [bfha_pkg::TYPE_BITS-1:0] kind;
		logic [AB-1:0]                  amt;

		start     = 1'b0;
		req       = '0;
		arst_n    = 1'b0;
		have_next = 1'b0;
		idle_left = 0;
		took_txn  = 1'b0;
		err_cnt   = 0;
		n_holes   = 0;
		waste_acc = 0;
		free_acc  = 0;
		for (i = 0; i < HOLES; i++) begin
			hole_sz[i]    = '0;
			hole_taken[i] = 1'b0;
		end

		// Directed: empty table, equal sizes, zero request, extremes, no fit, table full.
		add_txn(bfha_pkg::REQ_REPORT, 16'h0000, $urandom_range(0, GAP_MAX), 1'b0);
		add_txn(bfha_pkg::REQ_ALLOC,  16'h0000, $urandom_range(0, GAP_MAX), 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'd100,  $urandom_range(0, GAP_MAX), 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'hFFFF, 0, 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'h0000, 0, 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'd100,  $urandom_range(0, GAP_MAX), 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'd50,   $urandom_range(0, GAP_MAX), 1'b0);
		add_txn(bfha_pkg::REQ_ALLOC,  16'h0000, 0, 1'b0);
		add_txn(bfha_pkg::REQ_ALLOC,  16'h0000, $urandom_range(0, GAP_MAX), 1'b0);
		add_txn(bfha_pkg::REQ_ALLOC,  16'hFFFF, 0, 1'b0);
		add_txn(bfha_pkg::REQ_ALLOC,  16'hFFFF, $urandom_range(0, GAP_MAX), 1'b0);
		add_txn(bfha_pkg::REQ_ALLOC,  16'd100,  0, 1'b0);
		add_txn(bfha_pkg::REQ_ALLOC,  16'd99,   $urandom_range(0, GAP_MAX), 1'b0);
		add_txn(bfha_pkg::REQ_REPORT, 16'h5555, 0, 1'b1);
		add_txn(bfha_pkg::REQ_LOAD,   16'h8000, 0, 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'h4000, $urandom_range(0, GAP_MAX), 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'hFFFE, 0, 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'h1234, $urandom_range(0, GAP_MAX), 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'h7FFF, 0, 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'hC000, $urandom_range(0, GAP_MAX), 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'h0001, 0, 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'hA5A5, $urandom_range(0, GAP_MAX), 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'h5A5A, 0, 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'hF000, $urandom_range(0, GAP_MAX), 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'h0FFF, 0, 1'b0);
		add_txn(bfha_pkg::REQ_LOAD,   16'h2222, $urandom_range(0, GAP_MAX), 1'b0);
		add_txn(bfha_pkg::REQ_SPARE,  16'hFFFF, 0, 1'b0);

		// Random: mostly allocations of random size over the remaining free holes.
		burst = 1'b0;
		for (i = 0; i < N_RANDOM; i++) begin
			// Switch between back-to-back stretches and randomly gapped ones.
			if (i % 40 == 0)
				burst = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 15)
				kind = bfha_pkg::REQ_LOAD;
			else if (pick < 65)
				kind = bfha_pkg::REQ_ALLOC;
			else if (pick < 90)
				kind = bfha_pkg::REQ_REPORT;
			else
				kind = bfha_pkg::REQ_SPARE;
			if ($urandom_range(0, 3) == 0)
				amt = AB'($urandom_range(0, 255));
			else
				amt = AB'($urandom_range(0, 16'hFFFF));
			gap = burst ? 0 : $urandom_range(0, GAP_MAX);
			add_txn(kind, amt, gap, (i % 250 == 125));
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for all stimulus to be accepted, then for every result.
		while (pending_txn_q.size() != 0 || have_next || start)
			@(posedge clk);
		while (awaited_rsp_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (err_cnt == 0) begin
			$display("[best_fit_hole_allocator] OK");
		end else begin
			$display("[best_fit_hole_allocator] ERROR");
		end
		$finish;
	end

endmodule
